### hw/rtl/particle_pool_engine_unit_defines.svh
// Assertion macros for the RTL of the particle pool engine, used by ppe_back.
`ifndef PARTICLE_POOL_ENGINE_UNIT_DEFINES_SVH
`define PARTICLE_POOL_ENGINE_UNIT_DEFINES_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define PPE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Checks that an antecedent implies a consequent in the next cycle.
`define PPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hw/rtl/ppe_pkg.sv
`timescale 1ns / 1ps
package ppe_pkg;
   localparam int SLOTS_DEFAULT = 64;
   localparam int CMD_W = 2;
   localparam int KIND_W = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 24;
   localparam int LIFE_W = 16;
   localparam logic [LIFE_W-1:0] LIFE_ONE = 16'd32768;
   localparam int QDEPTH = 2;

   typedef enum logic [1:0] {
      CMD_ADD  = 2'd0,
      CMD_TICK = 2'd1,
      CMD_DRAW = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_CLAIM  = 2'd0,
      KIND_SPRITE = 2'd1,
      KIND_TICK   = 2'd2,
      KIND_EMPTY  = 2'd3
   } kind_type;

   localparam logic [CSR_IDX_W-1:0] CSR_SLOTS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY = 1'b1;

   // Request as it travels through the queue between front and back.
   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] vel_x;
      logic [31:0] vel_y;
      logic [31:0] color;
      logic [15:0] size;
      logic [15:0] delta_time;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_TICK_RD,
      ST_TICK_MUL,
      ST_TICK_WR,
      ST_DRAW,
      ST_OUT
   } state_type;
endpackage

### hw/rtl/ppe_front.sv
`timescale 1ns / 1ps
module ppe_front
   import ppe_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     q_valid,
   input  logic     q_take,
   output item_type q_item
);
   // Small FIFO; unused commands are dropped before they enter it.
   localparam int PW = $clog2(QDEPTH);
   item_type          mem_ff [QDEPTH];
   logic [PW-1:0]     wp_ff, wp_in, rp_ff, rp_in;
   logic [PW:0]       cnt_ff, cnt_in;
   logic              push, pop;

   assign in_ready = (cnt_ff != PW'(0) + (PW+1)'(QDEPTH));
   assign push = in_valid && in_ready && (in_item.cmd != CMD_NONE);
   assign pop  = q_take && q_valid;
   assign q_valid = (cnt_ff != '0);
   assign q_item = mem_ff[rp_ff];

   always_comb begin
      wp_in  = push ? PW'((32'(wp_ff) + 1) % QDEPTH) : wp_ff;
      rp_in  = pop ? PW'((32'(rp_ff) + 1) % QDEPTH) : rp_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_item;
   end
endmodule

### hw/rtl/ppe_back.sv
`timescale 1ns / 1ps
`include "particle_pool_engine_unit_defines.svh"
module ppe_back
   import ppe_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [6:0]        slots_in_use,
   input  logic [23:0]       decay_rate,
   input  logic              q_valid,
   output logic              q_take,
   input  item_type          q_item,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [1:0]        out_kind,
   output logic [5:0]        out_slot,
   output logic [31:0]       out_x,
   output logic [31:0]       out_y,
   output logic [15:0]       out_size,
   output logic [31:0]       out_color,
   output logic              out_last
);
   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   // Per-slot storage. One live bit per slot is kept in flip-flops so every
   // slot is free at reset; the life value itself sits in a memory.
   logic [SLOTS-1:0]  live_ff;
   logic [LIFE_W-1:0] life_mem [SLOTS];
   logic [31:0] px_mem [SLOTS];
   logic [31:0] py_mem [SLOTS];
   logic [31:0] vx_mem [SLOTS];
   logic [31:0] vy_mem [SLOTS];
   logic [31:0] col_mem [SLOTS];
   logic [15:0] sz_mem [SLOTS];

   state_type state_ff, state_in;
   item_type  it_ff, it_in;
   logic [IW-1:0] idx_ff, idx_in, start_ff, start_in;
   logic          pass_ff, pass_in, found_ff, found_in;
   logic [31:0]   rpx_ff, rpy_ff, rvx_ff, rvy_ff, rcol_ff;
   logic [15:0]   rsz_ff;
   logic [LIFE_W-1:0] rlife_ff;
   logic signed [48:0] mx_ff, my_ff;
   logic [24:0]   loss_ff;
   logic          ov_ff, ov_in;
   logic [1:0]    ok_ff, ok_in;
   logic [5:0]    os_ff, os_in;
   logic [31:0]   ox_ff, ox_in, oy_ff, oy_in, oc_ff, oc_in;
   logic [15:0]   oz_ff, oz_in;
   logic          ol_ff, ol_in;
   logic [CW-1:0] n;
   logic [CW-1:0] idx_ext;
   logic          is_last_idx, life_zero, any_later;
   logic          wr_add, wr_tick;
   logic [IW-1:0] wr_idx;
   logic [31:0]   npx, npy;
   logic [LIFE_W-1:0] nlife;

   always_comb begin
      if (slots_in_use == 7'd0) n = CW'(1);
      else if (32'(slots_in_use) > SLOTS) n = CW'(SLOTS);
      else n = CW'(slots_in_use);
   end

   assign idx_ext = CW'(idx_ff);
   assign is_last_idx = (idx_ext + CW'(1) >= n);
   assign life_zero = !live_ff[idx_ff];

   // Does any live slot follow idx within the active range (for the last mark)?
   always_comb begin
      any_later = 1'b0;
      for (int i = 0; i < SLOTS; i++)
         if (i > 32'(idx_ff) && i < 32'(n) && live_ff[i]) any_later = 1'b1;
   end

   assign npx = rpx_ff + 32'(mx_ff >>> 16);
   assign npy = rpy_ff + 32'(my_ff >>> 16);
   assign nlife = (32'(loss_ff) >= 32'(rlife_ff)) ? '0
                  : LIFE_W'(32'(rlife_ff) - 32'(loss_ff));

   always_comb begin
      state_in = state_ff;
      it_in = it_ff;
      idx_in = idx_ff;
      start_in = start_ff;
      pass_in = pass_ff;
      found_in = found_ff;
      ov_in = ov_ff;
      ok_in = ok_ff; os_in = os_ff; ox_in = ox_ff; oy_in = oy_ff;
      oz_in = oz_ff; oc_in = oc_ff; ol_in = ol_ff;
      q_take = 1'b0;
      wr_add = 1'b0;
      wr_tick = 1'b0;
      wr_idx = idx_ff;
      if (ov_ff && out_ready) ov_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // A new request starts only once the output register is free.
            if (q_valid && (!ov_ff || out_ready)) begin
               q_take = 1'b1;
               it_in = q_item;
               pass_in = 1'b0;
               case (q_item.cmd)
                  CMD_ADD: begin
                     idx_in = start_ff;
                     state_in = ST_SEARCH;
                  end
                  CMD_TICK: begin
                     idx_in = '0;
                     state_in = ST_TICK_RD;
                  end
                  CMD_DRAW: begin
                     idx_in = '0;
                     found_in = 1'b0;
                     state_in = ST_DRAW;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SEARCH: begin
            // First pass start..n-1, second pass 0..start-1; pool full gives 0.
            if (!pass_ff && idx_ext >= n) begin
               pass_in = 1'b1;
               idx_in = '0;
            end else if (pass_ff && (idx_ff >= start_ff || idx_ext >= n)) begin
               wr_add = 1'b1;
               wr_idx = '0;
               ok_in = KIND_CLAIM; os_in = '0;
               state_in = ST_OUT;
            end else if (life_zero) begin
               wr_add = 1'b1;
               start_in = idx_ff;
               ok_in = KIND_CLAIM; os_in = 6'(idx_ff);
               state_in = ST_OUT;
            end else begin
               idx_in = idx_ff + IW'(1);
               if (!pass_ff && is_last_idx) begin
                  pass_in = 1'b1;
                  idx_in = '0;
               end
            end
            ox_in = '0; oy_in = '0; oz_in = '0; oc_in = '0; ol_in = 1'b1;
         end
         ST_TICK_RD: state_in = ST_TICK_MUL;
         ST_TICK_MUL: state_in = ST_TICK_WR;
         ST_TICK_WR: begin
            if (!life_zero) wr_tick = 1'b1;
            if (is_last_idx) begin
               ok_in = KIND_TICK; os_in = '0; ox_in = '0; oy_in = '0;
               oz_in = '0; oc_in = '0; ol_in = 1'b1;
               state_in = ST_OUT;
            end else begin
               idx_in = idx_ff + IW'(1);
               state_in = ST_TICK_RD;
            end
         end
         ST_DRAW: begin
            // rpx..rcol hold the slot registered in the previous cycle; pass_ff marks data ready.
            if (!ov_ff || out_ready) begin
               if (!pass_ff) begin
                  pass_in = 1'b1;
               end else if (!life_zero) begin
                  ov_in = 1'b1;
                  found_in = 1'b1;
                  ok_in = KIND_SPRITE; os_in = 6'(idx_ff);
                  ox_in = rpx_ff; oy_in = rpy_ff; oz_in = rsz_ff; oc_in = rcol_ff;
                  ol_in = !any_later;
                  if (!any_later) state_in = ST_IDLE;
                  else begin
                     idx_in = idx_ff + IW'(1);
                     pass_in = 1'b0;
                  end
               end else if (is_last_idx) begin
                  if (found_ff) state_in = ST_IDLE;
                  else begin
                     ok_in = KIND_EMPTY; os_in = '0; ox_in = '0; oy_in = '0;
                     oz_in = '0; oc_in = '0; ol_in = 1'b1;
                     state_in = ST_OUT;
                  end
               end else begin
                  idx_in = idx_ff + IW'(1);
                  pass_in = 1'b0;
               end
            end
         end
         ST_OUT: begin
            if (!ov_ff || out_ready) begin
               ov_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         start_ff <= '0;
         ov_ff <= 1'b0;
         idx_ff <= '0;
         pass_ff <= 1'b0;
         found_ff <= 1'b0;
         live_ff <= '0;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
         ov_ff <= ov_in;
         idx_ff <= idx_in;
         pass_ff <= pass_in;
         found_ff <= found_in;
         if (wr_add) live_ff[wr_idx] <= 1'b1;
         if (wr_tick) live_ff[idx_ff] <= (nlife != '0);
      end
   end

   always_ff @(posedge clock) begin
      it_ff <= it_in;
      ok_ff <= ok_in; os_ff <= os_in; ox_ff <= ox_in; oy_ff <= oy_in;
      oz_ff <= oz_in; oc_ff <= oc_in; ol_ff <= ol_in;
      rpx_ff <= px_mem[idx_ff];
      rpy_ff <= py_mem[idx_ff];
      rvx_ff <= vx_mem[idx_ff];
      rvy_ff <= vy_mem[idx_ff];
      rcol_ff <= col_mem[idx_ff];
      rsz_ff <= sz_mem[idx_ff];
      rlife_ff <= life_mem[idx_ff];
      mx_ff <= $signed(rvx_ff) * $signed({1'b0, it_ff.delta_time});
      my_ff <= $signed(rvy_ff) * $signed({1'b0, it_ff.delta_time});
      loss_ff <= 25'((41'(decay_rate) * 41'(it_ff.delta_time)) >> 17);
      if (wr_add) begin
         life_mem[wr_idx] <= LIFE_ONE;
         px_mem[wr_idx] <= it_ff.pos_x;
         py_mem[wr_idx] <= it_ff.pos_y;
         vx_mem[wr_idx] <= it_ff.vel_x;
         vy_mem[wr_idx] <= it_ff.vel_y;
         col_mem[wr_idx] <= it_ff.color;
         sz_mem[wr_idx] <= it_ff.size;
      end
      if (wr_tick) begin
         life_mem[idx_ff] <= nlife;
         px_mem[idx_ff] <= npx;
         py_mem[idx_ff] <= npy;
      end
   end

   assign out_valid = ov_ff;
   assign out_kind = ok_ff;
   assign out_slot = os_ff;
   assign out_x = ox_ff;
   assign out_y = oy_ff;
   assign out_size = oz_ff;
   assign out_color = oc_ff;
   assign out_last = ol_ff;

   `PPE_ASSERT_IMP(a_take_idle, clock, reset, q_take, state_ff == ST_IDLE)
   `PPE_ASSERT_NEXT(a_add_live, clock, reset, wr_add, live_ff[$past(wr_idx)])
   `PPE_ASSERT_NEXT(a_hold, clock, reset, out_valid && !out_ready,
                    out_valid && $stable(out_slot) && $stable(out_kind))
   `PPE_ASSERT_IMP(a_one_write, clock, reset, wr_add, !wr_tick)
endmodule

### hw/rtl/particle_pool_engine_unit.sv
`timescale 1ns / 1ps
// Particle pool engine. Requests on req_ are add (claim a slot), tick (move and
// age every live slot in the active range) or draw (list those live slots);
// results leave on rsp_ with tlast on the last result of each request. A front
// FIFO of two requests sits ahead of a sequential back end. An add searches
// for a free slot, a tick reads, multiplies and writes back each active slot
// in turn, and a draw reads each active slot and emits it if live; each slot
// visit is one access to the slot memories. The back end starts a new request
// only once the previous result has left its output register. Configuration
// must be written through csr_ only while idle; the block does not enforce it.
module particle_pool_engine_unit
   import ppe_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // cmd[1:0], pos_x[33:2], pos_y[65:34], vel_x[97:66], vel_y[129:98],
   // color[161:130], size[177:162], delta_time[193:178], zero fill to 200
   input  logic [199:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // kind[1:0], slot[7:2], out_x[39:8], out_y[71:40], out_size[87:72],
   // out_color[119:88]
   output logic [119:0] rsp_tdata,
   output logic         rsp_tlast
);
   logic [6:0]  slots_ff;
   logic [23:0] decay_ff;
   item_type    in_item, q_item;
   logic        q_valid, q_take;

   // Register writes; indexes beyond the list fall through unused.
   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= 7'd64;
         decay_ff <= 24'd65536;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SLOTS: slots_ff <= csr_wdata[6:0];
            CSR_DECAY: decay_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      in_item.cmd = cmd_type'(req_tdata[1:0]);
      in_item.pos_x = req_tdata[33:2];
      in_item.pos_y = req_tdata[65:34];
      in_item.vel_x = req_tdata[97:66];
      in_item.vel_y = req_tdata[129:98];
      in_item.color = req_tdata[161:130];
      in_item.size = req_tdata[177:162];
      in_item.delta_time = req_tdata[193:178];
   end

   ppe_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item(in_item),
      .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
   );

   ppe_back #(.SLOTS(SLOTS)) u_back (
      .clock(clock), .reset(reset),
      .slots_in_use(slots_ff), .decay_rate(decay_ff),
      .q_valid(q_valid), .q_take(q_take), .q_item(q_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_kind(rsp_tdata[1:0]), .out_slot(rsp_tdata[7:2]),
      .out_x(rsp_tdata[39:8]), .out_y(rsp_tdata[71:40]),
      .out_size(rsp_tdata[87:72]), .out_color(rsp_tdata[119:88]),
      .out_last(rsp_tlast)
   );
endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the particle pool engine.
//
// Requests go in on the req_ stream and results come back on the rsp_ stream.
// The testbench keeps its own copy of the particle pool and works out, for
// every accepted request, the results that the block should produce. Those
// results wait in a queue and a monitor compares every accepted result with
// the oldest waiting one, field by field.
//
// Both stream sides idle at random. Once, the receiver holds off for a long
// stretch while requests keep coming, so that the block fills up and must
// stall its input. Registers are only written when the block is idle.
module tb_top;
   import ppe_pkg::*;

   localparam int POOL = 64;
   // Cycles to let pass after the last expected result, since a request
   // that returns nothing may still be at work (a tick visits every active
   // slot in turn).
   localparam int SETTLE_CYCLES = 3 * POOL + 40;
   localparam int HOLD_OFF_CYCLES = 400;

   // One result as the block should emit it.
   typedef struct {
      kind_type    kind;
      logic [5:0]  slot;
      logic [31:0] out_x;
      logic [31:0] out_y;
      logic [15:0] out_size;
      logic [31:0] out_color;
      logic        last;
   } result_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [199:0]          req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [119:0]          rsp_tdata;
   logic                  rsp_tlast;

   // Our own copy of the pool and of the two registers.
   logic [15:0] life_of   [POOL];
   logic [31:0] pos_x_of  [POOL];
   logic [31:0] pos_y_of  [POOL];
   logic [31:0] vel_x_of  [POOL];
   logic [31:0] vel_y_of  [POOL];
   logic [31:0] color_of  [POOL];
   logic [15:0] size_of   [POOL];
   logic [5:0]  next_free_hint;
   logic [6:0]  slot_count_reg;
   logic [23:0] decay_reg;

   result_type pending_results[$];
   int         error_count;
   bit         hold_off;
   bit         steady_flow;

   particle_pool_engine_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Mostly short gaps, a few long ones. No gaps at all while steady_flow
   // is set, which gives stretches of back-to-back traffic.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_flow || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Clamp of the slot count register: zero acts as one, above the pool as
   // the pool size.
   function automatic int live_range();
      if (slot_count_reg == 0) return 1;
      if (slot_count_reg > POOL) return POOL;
      return slot_count_reg;
   endfunction

   // Velocity times delta, shifted down by 16 with rounding toward minus
   // infinity; the arithmetic shift of a signed product does exactly that.
   function automatic logic [31:0] motion_step(logic [31:0] vel, logic [15:0] dt);
      longint prod;
      prod = longint'($signed(vel)) * longint'({16'd0, dt});
      return 32'(prod >>> 16);
   endfunction

   function automatic result_type make_result(kind_type k, logic [5:0] s, logic fin);
      result_type r;
      r.kind = k;
      r.slot = s;
      r.out_x = '0;
      r.out_y = '0;
      r.out_size = '0;
      r.out_color = '0;
      r.last = fin;
      return r;
   endfunction

   // Updates the pool copy for one accepted request and queues the results
   // that it should produce.
   task automatic predict_pool(logic [199:0] word);
      logic [1:0]  cmd;
      logic [15:0] dt;
      logic [63:0] loss;
      int          n;
      int          found;
      int          listed;
      result_type  r;
      cmd = word[1:0];
      dt  = word[193:178];
      n   = live_range();
      case (cmd)
         CMD_ADD: begin
            // Search from the hint to the end, then wrap to the start. With
            // the pool full, slot 0 is overwritten and the hint stays.
            found = -1;
            for (int i = next_free_hint; i < n && found < 0; i++)
               if (life_of[i] == 0) found = i;
            for (int i = 0; i < next_free_hint && i < n && found < 0; i++)
               if (life_of[i] == 0) found = i;
            if (found >= 0) next_free_hint = 6'(found);
            else found = 0;
            life_of[found]  = LIFE_ONE;
            pos_x_of[found] = word[33:2];
            pos_y_of[found] = word[65:34];
            vel_x_of[found] = word[97:66];
            vel_y_of[found] = word[129:98];
            color_of[found] = word[161:130];
            size_of[found]  = word[177:162];
            pending_results.push_back(make_result(KIND_CLAIM, 6'(found), 1'b1));
         end
         CMD_TICK: begin
            loss = (64'(decay_reg) * 64'(dt)) >> 17;
            for (int i = 0; i < n; i++) begin
               if (life_of[i] != 0) begin
                  pos_x_of[i] += motion_step(vel_x_of[i], dt);
                  pos_y_of[i] += motion_step(vel_y_of[i], dt);
                  if (loss >= 64'(life_of[i])) life_of[i] = '0;
                  else life_of[i] = life_of[i] - 16'(loss);
               end
            end
            pending_results.push_back(make_result(KIND_TICK, '0, 1'b1));
         end
         CMD_DRAW: begin
            listed = 0;
            for (int i = 0; i < n; i++) begin
               if (life_of[i] != 0) begin
                  r = make_result(KIND_SPRITE, 6'(i), 1'b0);
                  r.out_x = pos_x_of[i];
                  r.out_y = pos_y_of[i];
                  r.out_size = size_of[i];
                  r.out_color = color_of[i];
                  pending_results.push_back(r);
                  listed++;
               end
            end
            if (listed == 0) pending_results.push_back(make_result(KIND_EMPTY, '0, 1'b1));
            else pending_results[$].last = 1'b1;
         end
         default: begin
            // The unused command is dropped without a result.
         end
      endcase
   endtask

   // Offers one request, waits for it to be taken, then maybe idles.
   task automatic send_request(cmd_type cmd, logic [31:0] px, logic [31:0] py,
                               logic [31:0] vx, logic [31:0] vy, logic [31:0] col,
                               logic [15:0] sz, logic [15:0] dt);
      logic [199:0] word;
      int           gap;
      word = {6'd0, dt, sz, col, vy, vx, py, px, cmd};
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_pool(word);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_add(logic [15:0] sz);
      send_request(CMD_ADD, $urandom, $urandom, $urandom, $urandom, $urandom, sz,
                   16'($urandom));
   endtask

   // Random delta: mostly short ticks so particles live a while, some long.
   task automatic send_tick();
      logic [15:0] dt;
      dt = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 3000)) : 16'($urandom);
      send_request(CMD_TICK, $urandom, $urandom, $urandom, $urandom, $urandom,
                   16'($urandom), dt);
   endtask

   task automatic send_draw();
      send_request(CMD_DRAW, $urandom, $urandom, $urandom, $urandom, $urandom,
                   16'($urandom), 16'($urandom));
   endtask

   // Waits until every expected result has arrived and the block has had
   // time to finish any request that returns nothing.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_SLOTS) slot_count_reg = value[6:0];
      else decay_reg = value;
   endtask

   // Small pool: field extremes, pool full overwrite, every command, ticks at
   // the delta extremes and a draw that finds nothing.
   task automatic test_directed_pool();
      write_register(CSR_SLOTS, 24'd4);
      write_register(CSR_DECAY, 24'hFFFFFF);
      send_request(CMD_DRAW, '0, '0, '0, '0, '0, '0, '0);
      send_request(CMD_ADD, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                   32'hFFFFFFFF, 16'hFFFF, 16'hFFFF);
      send_request(CMD_ADD, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                   32'h00000000, 16'h0000, 16'h0000);
      send_request(CMD_ADD, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 32'h1, 32'hA5A5A5A5,
                   16'h5A5A, 16'h0);
      send_request(CMD_ADD, 32'h0, 32'hFFFFFFFF, 32'h1, 32'hFFFFFFFF, 32'h5A5A5A5A,
                   16'hA5A5, 16'h0);
      // The pool of four is now full, so this one lands on slot 0.
      send_request(CMD_ADD, 32'h12345678, 32'h9ABCDEF0, 32'h00010000, 32'hFFFF0000,
                   32'h01020304, 16'h0100, 16'h0);
      send_request(CMD_DRAW, '0, '0, '0, '0, '0, '0, '0);
      send_request(CMD_TICK, '0, '0, '0, '0, '0, '0, 16'h0000);
      send_request(CMD_NONE, $urandom, $urandom, $urandom, $urandom, $urandom,
                   16'hFFFF, 16'hFFFF);
      send_request(CMD_DRAW, '0, '0, '0, '0, '0, '0, '0);
      // Largest loss times largest delta empties every slot at once.
      send_request(CMD_TICK, '0, '0, '0, '0, '0, '0, 16'hFFFF);
      send_request(CMD_DRAW, '0, '0, '0, '0, '0, '0, '0);
      wait_idle();
      // No decay: a long tick moves particles but keeps them alive.
      write_register(CSR_DECAY, 24'd0);
      write_register(CSR_SLOTS, 24'd1);
      send_add(16'hFFFF);
      send_add(16'h0001);
      send_request(CMD_TICK, '0, '0, '0, '0, '0, '0, 16'hFFFF);
      send_draw();
      wait_idle();
   endtask

   // A count of zero acts as one and a count above the pool as the pool. A
   // search hint beyond a reduced count finds nothing on its first pass.
   task automatic test_slot_count_limits();
      write_register(CSR_SLOTS, 24'd0);
      send_add(16'($urandom));
      send_draw();
      wait_idle();
      write_register(CSR_SLOTS, 24'd127);
      write_register(CSR_DECAY, 24'd65536);
      for (int i = 0; i < 12; i++) send_add(16'($urandom));
      send_draw();
      wait_idle();
      write_register(CSR_SLOTS, 24'd6);
      send_add(16'($urandom));
      send_add(16'($urandom));
      send_draw();
      wait_idle();
   endtask

   // The receiver stops for a long time while requests keep coming.
   task automatic test_backpressure();
      write_register(CSR_SLOTS, 24'd16);
      hold_off = 1'b1;
      for (int i = 0; i < 10; i++) send_add(16'($urandom));
      send_draw();
      send_tick();
      wait_idle();
   endtask

   // Well-formed mixes of adds, ticks and draws under several settings,
   // with a little of the unused command as noise.
   task automatic test_random_mix();
      int r;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_register(CSR_SLOTS, 24'd8);
            1: write_register(CSR_SLOTS, 24'd64);
            2: write_register(CSR_SLOTS, 24'($urandom_range(1, 32)));
            3: write_register(CSR_SLOTS, 24'd2);
            4: write_register(CSR_SLOTS, 24'($urandom_range(65, 127)));
            default: write_register(CSR_SLOTS, 24'($urandom_range(0, 20)));
         endcase
         case (phase % 3)
            0: write_register(CSR_DECAY, 24'($urandom_range(0, 200000)));
            1: write_register(CSR_DECAY, 24'd65536);
            default: write_register(CSR_DECAY, 24'($urandom));
         endcase
         steady_flow = (phase == 2);
         for (int i = 0; i < 48; i++) begin
            r = $urandom_range(0, 99);
            if (r < 50) send_add(16'($urandom));
            else if (r < 72) send_tick();
            else if (r < 95) send_draw();
            else send_request(CMD_NONE, $urandom, $urandom, $urandom, $urandom,
                              $urandom, 16'($urandom), 16'($urandom));
         end
         steady_flow = 1'b0;
         wait_idle();
      end
   endtask

   // Receiver side: random stalls, and one long hold-off on request.
   initial begin
      int gap;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off = 1'b0;
         end else begin
            gap = pick_gap();
            if (gap == 0) begin
               rsp_tready <= 1'b1;
               @(posedge clock);
            end else begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
               rsp_tready <= 1'b1;
               @(posedge clock);
            end
         end
      end
   end

   // Compares every accepted result with the oldest expected one.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: tdata %h tlast %b", rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[1:0] !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_tdata[1:0]);
               error_count++;
            end
            if (rsp_tdata[7:2] !== want.slot) begin
               $error("slot: expected %0d, got %0d", want.slot, rsp_tdata[7:2]);
               error_count++;
            end
            if (rsp_tdata[39:8] !== want.out_x) begin
               $error("out_x: expected %h, got %h", want.out_x, rsp_tdata[39:8]);
               error_count++;
            end
            if (rsp_tdata[71:40] !== want.out_y) begin
               $error("out_y: expected %h, got %h", want.out_y, rsp_tdata[71:40]);
               error_count++;
            end
            if (rsp_tdata[87:72] !== want.out_size) begin
               $error("out_size: expected %h, got %h", want.out_size, rsp_tdata[87:72]);
               error_count++;
            end
            if (rsp_tdata[119:88] !== want.out_color) begin
               $error("out_color: expected %h, got %h", want.out_color, rsp_tdata[119:88]);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %b, got %b", want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   initial begin
      reset      <= 1'b1;
      csr_we     <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      error_count = 0;
      hold_off    = 1'b0;
      steady_flow = 1'b0;
      for (int i = 0; i < POOL; i++) begin
         life_of[i]  = '0;
         pos_x_of[i] = '0;
         pos_y_of[i] = '0;
         vel_x_of[i] = '0;
         vel_y_of[i] = '0;
         color_of[i] = '0;
         size_of[i]  = '0;
      end
      next_free_hint = '0;
      slot_count_reg = 7'd64;
      decay_reg      = 24'd65536;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);

      test_directed_pool();
      test_slot_count_limits();
      test_backpressure();
      test_random_mix();

      if (pending_results.size() != 0) begin
         $error("%0d expected results never arrived", pending_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Guards against a hang; far beyond the slowest correct run.
   initial begin
      #50_000_000;
      $display("Regression FAIL");
      $finish;
   end
endmodule
